// File: hdl/ctg_pkg.sv
`default_nettype none

package ctg_pkg;

  // Sine table geometry: one quarter wave plus the end point
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
  localparam int QBITS            = $clog2(QUARTER);
  localparam int LENGTH_BITS      = 20;

  // Output divisor: full sine times full envelope
  localparam logic [30:0] DIV_D = 31'd2147385345;  // 32767 * 65535

  // Register reset values
  localparam logic [19:0] RST_LENGTH     = 20'd4851;
  localparam logic [30:0] RST_START_STEP = 31'd85704559;
  localparam logic [31:0] RST_SWEEP      = 32'd23321;
  localparam logic [15:0] RST_DECAY      = 16'd65518;
  localparam logic [14:0] RST_PEAK       = 15'd26000;

  localparam logic [15:0] FULL_ENV = 16'hFFFF;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_LENGTH     = 3'd0,
    REG_START_STEP = 3'd1,
    REG_SWEEP      = 3'd2,
    REG_DECAY      = 3'd3,
    REG_PEAK       = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [19:0]        length;
    logic [30:0]        start_step;
    logic signed [31:0] sweep_step;
    logic [15:0]        decay_factor;
    logic [14:0]        peak_amplitude;
  } cfg_t;

  // Sequencer states
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_PHASE   = 10'b00_0000_0010,
    ST_ROM     = 10'b00_0000_0100,
    ST_MUL_SE  = 10'b00_0000_1000,
    ST_MUL_PK  = 10'b00_0001_0000,
    ST_MUL_ENV = 10'b00_0010_0000,
    ST_MUL_QD  = 10'b00_0100_0000,
    ST_SUB     = 10'b00_1000_0000,
    ST_CORR    = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_t;

  // Odd polynomial for sin(pi/2 * u), Q30, Horner in u^2
  localparam logic [63:0] POLY_Q30 [0:5] = '{
    64'd1686629713, 64'd693598672, 64'd85569300,
    64'd5027000, 64'd172270, 64'd3864
  };

  typedef logic [14:0] sine_rom_t [0:QUARTER];

  // Quarter-wave magnitudes, worked out at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] acc;
    for (int k = 0; k <= QUARTER; k++) begin
      u   = 64'(k) << (30 - QBITS);
      u2  = (u * u) >> 30;
      acc = POLY_Q30[5];
      for (int i = 4; i >= 0; i--) begin
        acc = POLY_Q30[i] - ((acc * u2) >> 30);
      end
      acc = (acc * u) >> 30;
      acc = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      if (acc > 64'd32767) begin
        acc = 64'd32767;
      end
      rom[k] = acc[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// File: hdl/ctg_regs.sv
`default_nettype none

module ctg_regs
  import ctg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[4:2]);

  // Register writes; unused indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length         <= RST_LENGTH;
      cfg.start_step     <= RST_START_STEP;
      cfg.sweep_step     <= RST_SWEEP;
      cfg.decay_factor   <= RST_DECAY;
      cfg.peak_amplitude <= RST_PEAK;
    end else if (wr_en) begin
      unique case (idx)
        REG_LENGTH:     cfg.length         <= pwdata[19:0];
        REG_START_STEP: cfg.start_step     <= pwdata[30:0];
        REG_SWEEP:      cfg.sweep_step     <= pwdata;
        REG_DECAY:      cfg.decay_factor   <= pwdata[15:0];
        REG_PEAK:       cfg.peak_amplitude <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_LENGTH:     prdata = {12'd0, cfg.length};
      REG_START_STEP: prdata = {1'b0, cfg.start_step};
      REG_SWEEP:      prdata = cfg.sweep_step;
      REG_DECAY:      prdata = {16'd0, cfg.decay_factor};
      REG_PEAK:       prdata = {17'd0, cfg.peak_amplitude};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ctg_mul.sv
`default_nettype none

module ctg_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [15:0] b,
  output logic      [47:0] prod
);

  // Shared 32x16 multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= 48'(a) * 48'(b);
  end

endmodule

`default_nettype wire

// File: hdl/ctg_seq.sv
`default_nettype none

module ctg_seq
  import ctg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               tick_valid,
  output logic                    tick_stall,
  input  wire logic               restart,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [15:0]      sample,
  output logic                    last,
  output logic                    active,
  output logic        [31:0]      mul_a,
  output logic        [15:0]      mul_b,
  input  wire logic   [47:0]      mul_prod
);

  state_t state;
  state_t state_next;

  // Voice state
  logic [31:0]            phase;
  logic [31:0]            phase_step;
  logic [15:0]            envelope;
  logic [LENGTH_BITS-1:0] sample_index;
  logic                   running;

  // Working registers for one item
  logic [QBITS:0] rom_idx;
  logic [14:0]    sine_mag;
  logic           neg;
  logic [45:0]    prod_x;
  logic [32:0]    rem;
  logic [15:0]    quot;
  logic           is_last;
  logic           is_active;

  // Combinational helpers
  logic [31:0]            phase_next;
  logic [QBITS-1:0]       quarter_pos;
  logic signed [33:0]     step_sum;
  logic [31:0]            step_sat;
  logic [LENGTH_BITS-1:0] index_inc;
  logic [LENGTH_BITS-1:0] len_eff;
  logic                   can_load;

  assign tick_stall  = (state != ST_IDLE);
  assign can_load    = !result_valid || !result_stall;
  assign phase_next  = phase + phase_step;
  assign quarter_pos = phase_next[29 -: QBITS];
  assign index_inc   = sample_index + 1'b1;
  assign len_eff     = LENGTH_BITS'(cfg.length);

  // Phase step plus sweep, held within zero and Nyquist
  always_comb begin
    step_sum = $signed({2'b00, phase_step})
             + $signed({{2{cfg.sweep_step[31]}}, cfg.sweep_step});
    if (step_sum < 34'sd0) begin
      step_sat = 32'd0;
    end else if (step_sum > 34'sh0_8000_0000) begin
      step_sat = 32'h8000_0000;
    end else begin
      step_sat = step_sum[31:0];
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 16'd0;
    unique case (state)
      ST_MUL_SE: begin
        mul_a = {17'd0, sine_mag};
        mul_b = envelope;
      end
      ST_MUL_PK: begin
        mul_a = {1'b0, mul_prod[30:0]};
        mul_b = {1'b0, cfg.peak_amplitude};
      end
      ST_MUL_ENV: begin
        mul_a = {16'd0, envelope};
        mul_b = cfg.decay_factor;
      end
      ST_MUL_QD: begin
        mul_a = {1'b0, DIV_D};
        mul_b = {1'b0, prod_x[45:31]};
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_valid) begin
          state_next = (restart || running) ? ST_PHASE : ST_DONE;
        end
      end
      ST_PHASE:   state_next = ST_ROM;
      ST_ROM:     state_next = ST_MUL_SE;
      ST_MUL_SE:  state_next = ST_MUL_PK;
      ST_MUL_PK:  state_next = ST_MUL_ENV;
      ST_MUL_ENV: state_next = ST_MUL_QD;
      ST_MUL_QD:  state_next = ST_SUB;
      ST_SUB:     state_next = ST_CORR;
      ST_CORR: begin
        if (rem < 33'(DIV_D)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running      <= 1'b0;
      phase        <= 32'd0;
      phase_step   <= 32'd0;
      envelope     <= FULL_ENV;
      sample_index <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      // Restart resets the voice before this tick's sample
      if (state == ST_IDLE && tick_valid && restart) begin
        running      <= 1'b1;
        phase        <= 32'd0;
        phase_step   <= {1'b0, cfg.start_step};
        envelope     <= FULL_ENV;
        sample_index <= '0;
      end

      // Advance phase, step and count
      if (state == ST_PHASE) begin
        phase        <= phase_next;
        phase_step   <= step_sat;
        sample_index <= index_inc;
        if (index_inc >= len_eff) begin
          running <= 1'b0;
        end
      end

      // Envelope decay, product of the previous cycle
      if (state == ST_MUL_QD) begin
        envelope <= mul_prod[31:16];
      end

      // Output register
      if (state == ST_DONE && can_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        quot      <= 16'd0;
        neg       <= 1'b0;
        is_last   <= 1'b0;
        is_active <= restart || running;
      end
      ST_PHASE: begin
        rom_idx <= phase_next[30] ? ((QBITS+1)'(QUARTER) - {1'b0, quarter_pos})
                                  : {1'b0, quarter_pos};
        neg     <= phase_next[31];
        is_last <= (index_inc >= len_eff);
      end
      ST_ROM:     sine_mag <= SINE_ROM[rom_idx];
      ST_MUL_ENV: prod_x   <= mul_prod[45:0];
      ST_MUL_QD:  quot     <= {1'b0, prod_x[45:31]};
      ST_SUB:     rem      <= 33'(prod_x - mul_prod[45:0]);
      ST_CORR: begin
        // At most two corrections: the estimate is never above the quotient
        if (rem >= 33'(DIV_D)) begin
          rem  <= rem - 33'(DIV_D);
          quot <= quot + 1'b1;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          sample <= neg ? (16'sd0 - $signed(quot)) : $signed(quot);
          last   <= is_last;
          active <= is_active;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/chirp_tone_generator_top.sv
// Linear-chirp sine voice with exponential decay. Each accepted tick item
// yields one result item: a signed sample, plus last and active flags.
// restart=1 begins a burst of 'length' samples; between bursts the result is
// zero with active low. An active tick runs through phase step, table read,
// multiplies and up to two quotient correction steps; a tick while idle skips
// them. The work is paced by the single shared 32x16 multiplier, used four
// times per sample in turn (sine times envelope, times peak, envelope decay,
// quotient estimate times divisor), and the one-port sine table read.
// tick_stall is high while a tick is in work. A finished result waits in an
// output register, so the next tick is taken while it is stalled. Registers
// sit on an APB-style port at byte addresses 4*i: length, start_phase_step,
// sweep_step, decay_factor, peak_amplitude.
`default_nettype none

module chirp_tone_generator_top
  import ctg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               tick_valid,
  output logic                    tick_stall,
  input  wire logic               restart,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [15:0]      sample,
  output logic                    last,
  output logic                    active
);

  cfg_t        cfg;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_prod;

  ctg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  ctg_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .restart      (restart),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample),
    .last         (last),
    .active       (active),
    .mul_a        (mul_a),
    .mul_b        (mul_b),
    .mul_prod     (mul_prod)
  );

endmodule

`default_nettype wire

// File: hdl/ctg_checker.sv
`default_nettype none

module ctg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               tick_valid,
  input wire logic               tick_stall,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [15:0] sample,
  input wire logic               last,
  input wire logic               active
);

  // An accepted tick is still in work in the cycle after accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall |=> tick_stall)
    else $error("tick taken back to back");

  // Idle results are silent
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !active |-> sample == 16'sd0 && !last)
    else $error("idle result not zero");

  // Burst end only on a burst sample
  a_last_active: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> active)
    else $error("last without active");

  // Sample magnitude never reaches the most negative code
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample != -16'sd32768)
    else $error("sample out of range");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(sample) && $stable(last) && $stable(active))
    else $error("stalled result changed");

endmodule

bind chirp_tone_generator_top ctg_checker u_chk (.*);

`default_nettype wire

// File: dv/tb_chirp_tone_generator_top.sv
`default_nettype none

module tb_chirp_tone_generator_top;
  import ctg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 8;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          LIMIT_CYCLES  = 1_000_000;
  localparam int          QSIZE         = 256;         // quarter-wave table steps
  localparam longint      OUT_DIV       = 64'd2147385345;  // full sine * full envelope
  localparam longint      NYQ_STEP      = 64'd2147483648;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RANDOM_TICKS  = 170;
  localparam logic [2:0]  SPARE_REG_LO  = 3'd5;
  localparam logic [2:0]  SPARE_REG_HI  = 3'd7;
  localparam logic [15:0] ENV_FULL      = 16'hFFFF;

  // Q30 odd polynomial for the quarter sine, Horner form in u^2
  localparam bit [63:0] SINE_POLY [6] = '{
    64'd1686629713, 64'd693598672, 64'd85569300, 64'd5027000, 64'd172270, 64'd3864
  };

  typedef struct {
    logic signed [15:0] pcm;
    logic               last_flag;
    logic               active_flag;
  } voice_out_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               tick_valid = 1'b0;
  logic               tick_stall;
  logic               restart = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [15:0] sample;
  logic               last;
  logic               active;

  chirp_tone_generator_top dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .restart     (restart),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sample      (sample),
    .last        (last),
    .active      (active)
  );

  // Voice registers as the block should hold them
  logic [19:0]        cfg_length;
  logic [30:0]        cfg_start;
  logic signed [31:0] cfg_sweep;
  logic [15:0]        cfg_decay;
  logic [14:0]        cfg_peak;

  // Voice state
  logic [31:0] voice_phase;
  logic [31:0] voice_step;
  logic [15:0] voice_env;
  logic [19:0] voice_index;
  logic        voice_running;

  int quarter_wave [0:QSIZE];

  voice_out_t expected_samples [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left    = 0;
  int mismatches   = 0;
  int cycles       = 0;
  int tick_count   = 0;
  int burst_samples = 0;
  int burst_ends   = 0;
  int reg_writes   = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Quarter-wave magnitude for table step k
  function automatic int sine_magnitude(input int k);
    bit [63:0] u;
    bit [63:0] u2;
    bit [63:0] acc;
    u   = (64'(k) << 30) / QSIZE;
    u2  = (u * u) >> 30;
    acc = SINE_POLY[5];
    for (int i = 4; i >= 0; i--) begin
      acc = SINE_POLY[i] - ((acc * u2) >> 30);
    end
    acc = (acc * u) >> 30;
    acc = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    if (acc > 64'd32767) begin
      acc = 64'd32767;
    end
    return int'(acc);
  endfunction

  function automatic void reset_voice_model();
    for (int k = 0; k <= QSIZE; k++) begin
      quarter_wave[k] = sine_magnitude(k);
    end
    cfg_length    = 20'd4851;
    cfg_start     = 31'd85704559;
    cfg_sweep     = 32'sd23321;
    cfg_decay     = 16'd65518;
    cfg_peak      = 15'd26000;
    voice_phase   = '0;
    voice_step    = '0;
    voice_env     = ENV_FULL;
    voice_index   = '0;
    voice_running = 1'b0;
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_LENGTH:     return {12'd0, cfg_length};
      REG_START_STEP: return {1'b0, cfg_start};
      REG_SWEEP:      return cfg_sweep;
      REG_DECAY:      return {16'd0, cfg_decay};
      REG_PEAK:       return {17'd0, cfg_peak};
      default:        return '0;
    endcase
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      REG_LENGTH:     cfg_length = value[19:0];
      REG_START_STEP: cfg_start  = value[30:0];
      REG_SWEEP:      cfg_sweep  = value;
      REG_DECAY:      cfg_decay  = value[15:0];
      REG_PEAK:       cfg_peak   = value[14:0];
      default:        ;
    endcase
  endfunction

  // One sample tick of the voice: advance the phase, look up the sine, scale,
  // then sweep the step, decay the envelope and count the burst
  function automatic voice_out_t next_voice_sample(input logic rs);
    voice_out_t  r;
    logic [1:0]  quad;
    logic [7:0]  j;
    int          rom_idx;
    longint      mag;
    longint      nxt;
    logic [31:0] env_prod;
    r.pcm         = '0;
    r.last_flag   = 1'b0;
    r.active_flag = 1'b0;
    if (rs) begin
      voice_phase   = '0;
      voice_index   = '0;
      voice_env     = ENV_FULL;
      voice_step    = {1'b0, cfg_start};
      voice_running = 1'b1;
    end
    if (!voice_running) begin
      return r;
    end
    voice_phase = voice_phase + voice_step;
    quad    = voice_phase[31:30];
    j       = voice_phase[29:22];
    rom_idx = quad[0] ? QSIZE - int'(j) : int'(j);
    mag = longint'(quarter_wave[rom_idx]) * longint'(voice_env) * longint'(cfg_peak);
    mag = mag / OUT_DIV;
    if (quad[1]) begin
      mag = -mag;
    end
    r.pcm = mag[15:0];
    // step saturates between zero and Nyquist
    nxt = longint'(voice_step) + longint'(cfg_sweep);
    if (nxt < 0) begin
      nxt = 0;
    end
    if (nxt > NYQ_STEP) begin
      nxt = NYQ_STEP;
    end
    voice_step  = nxt[31:0];
    env_prod    = voice_env * cfg_decay;
    voice_env   = env_prod[31:16];
    voice_index = voice_index + 20'd1;
    r.last_flag = (voice_index >= cfg_length);
    if (r.last_flag) begin
      voice_running = 1'b0;
    end
    r.active_flag = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
  endtask

  // Register access, setup then access cycle
  task automatic reg_read(input logic [2:0] idx, output logic [31:0] data);
    logic rdy;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      data = prdata;
      rdy  = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(input logic [2:0] idx);
    logic [31:0] data;
    reg_read(idx, data);
    if (data !== reg_value(idx)) begin
      report_mismatch($sformatf("register %0d reads %h, want %h", idx, data, reg_value(idx)));
    end
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, value);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_PEAK) begin
      reg_check(idx);
    end
  endtask

  // Offer one tick item, with a random gap ahead of it
  task automatic send_tick(input logic rs);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk); while (tick_stall);
    expected_samples.push_back(next_voice_sample(rs));
    tick_count++;
  endtask

  task automatic stop_ticks();
    tick_valid <= 1'b0;
    restart    <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= (rcv_idle_pct > 0) && ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk) begin
    voice_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected result: sample %0d last %b active %b",
                                  sample, last, active));
      end else begin
        want = expected_samples.pop_front();
        if (want.active_flag) burst_samples++;
        if (want.last_flag) burst_ends++;
        if (sample !== want.pcm) begin
          report_mismatch($sformatf("sample %0d, want %0d", sample, want.pcm));
        end
        if (last !== want.last_flag) begin
          report_mismatch($sformatf("last %b, want %b", last, want.last_flag));
        end
        if (active !== want.active_flag) begin
          report_mismatch($sformatf("active %b, want %b", active, want.active_flag));
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Reset values read back; writes past the register list are dropped
  task automatic test_register_access();
    for (int i = REG_LENGTH; i <= REG_PEAK; i++) begin
      reg_check(3'(i));
    end
    reg_write(SPARE_REG_LO, 32'hFFFF_FFFF);
    reg_write(SPARE_REG_HI, 32'h0000_0001);
  endtask

  // Ticks before any burst give silence
  task automatic test_idle_ticks();
    send_tick(1'b0);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
  endtask

  // Head of a burst with reset settings
  task automatic test_default_burst();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
  endtask

  // Length of one and zero, restart in mid burst, length lowered in mid burst
  task automatic test_burst_length_edges();
    reg_write(REG_LENGTH, 32'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
    reg_write(REG_LENGTH, 32'd0);
    send_tick(1'b1);
    stop_ticks();
    wait_for_results();
    reg_write(REG_LENGTH, 32'd6);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
    reg_write(REG_LENGTH, 32'd1);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
  endtask

  // Step saturation at Nyquist and at zero, amplitude and decay extremes
  task automatic test_step_saturation();
    reg_write(REG_LENGTH, 32'd8);
    reg_write(REG_START_STEP, 32'h7FFF_FFFF);
    reg_write(REG_SWEEP, 32'h7FFF_FFFF);
    reg_write(REG_PEAK, 32'h0000_7FFF);
    reg_write(REG_DECAY, 32'h0000_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
    reg_write(REG_START_STEP, 32'h2000_0000);
    reg_write(REG_SWEEP, 32'h8000_0000);
    reg_write(REG_DECAY, 32'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
    reg_write(REG_START_STEP, 32'd0);
    reg_write(REG_SWEEP, 32'd0);
    reg_write(REG_PEAK, 32'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    stop_ticks();
    wait_for_results();
  endtask

  // Receiver holds off while ticks keep coming, so the block backs up
  task automatic test_output_backpressure();
    reg_write(REG_LENGTH, 32'd30);
    reg_write(REG_START_STEP, 32'd85704559);
    reg_write(REG_SWEEP, 32'd23321);
    reg_write(REG_DECAY, 32'd65518);
    reg_write(REG_PEAK, 32'd26000);
    hold_left = HOLD_CYCLES;
    send_tick(1'b1);
    repeat (39) send_tick(1'b0);
    stop_ticks();
    wait_for_results();
  endtask

  task automatic randomize_config();
    logic [31:0] v;
    case ($urandom_range(5))
      0:       v = 32'd0;
      1:       v = 32'd1;
      2:       v = 32'h000F_FFFF;
      default: v = $urandom_range(2, 60);
    endcase
    reg_write(REG_LENGTH, v);
    case ($urandom_range(4))
      0:       v = 32'd0;
      1:       v = 32'h7FFF_FFFF;
      2:       v = $urandom();
      default: v = $urandom_range(32'h0100_0000, 32'h2000_0000);
    endcase
    reg_write(REG_START_STEP, v);
    case ($urandom_range(5))
      0:       v = 32'd0;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'h8000_0000;
      3:       v = $urandom();
      default: v = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
    reg_write(REG_SWEEP, v);
    case ($urandom_range(4))
      0:       v = 32'd0;
      1:       v = 32'h0000_FFFF;
      2:       v = $urandom();
      default: v = $urandom_range(60000, 65535);
    endcase
    reg_write(REG_DECAY, v);
    case ($urandom_range(3))
      0:       v = 32'd0;
      1:       v = 32'h0000_7FFF;
      default: v = $urandom();
    endcase
    reg_write(REG_PEAK, v);
  endtask

  // Random bursts: restart mostly when idle, now and then in mid burst
  task automatic test_random_bursts(input int snd_pct, input int rcv_pct);
    logic rs;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (3) begin
      randomize_config();
      for (int n = 0; n < RANDOM_TICKS; n++) begin
        if (voice_running) begin
          rs = ($urandom_range(99) < 3);
        end else begin
          rs = ($urandom_range(99) < 60);
        end
        send_tick(rs);
      end
      stop_ticks();
      wait_for_results();
    end
  endtask

  initial begin
    reset_voice_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_idle_ticks();
    test_default_burst();
    test_burst_length_edges();
    test_step_saturation();
    test_output_backpressure();
    test_random_bursts(35, 74);
    test_random_bursts(74, 35);
    test_random_bursts(0, 0);

    wait_for_results();
    $display("covered %0d ticks: %0d burst samples, %0d burst ends, %0d register writes",
             tick_count, burst_samples, burst_ends, reg_writes);
    $display("incl. zero/one length, step saturation both ways, a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: chirp_tone_generator_top.f
hdl/ctg_pkg.sv
hdl/ctg_regs.sv
hdl/ctg_mul.sv
hdl/ctg_seq.sv
hdl/chirp_tone_generator_top.sv
hdl/ctg_checker.sv
dv/tb_chirp_tone_generator_top.sv
